// ===== sv/qmn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared widths and sideband types for the normalized quaternion product.
// ----------------------------------------------------------------------------
package qmn_pkg;

  localparam int unsigned COMP_W = 16;
  localparam int unsigned LANES  = 4;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned RAW_W  = 34;
  localparam int unsigned MAG_W  = 31;
  localparam int unsigned SQ_W   = 62;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned REM_W  = 36;

  typedef logic [LANES-1:0][MAG_W-1:0] mag_vec_t;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } div_side_t;

endpackage

// ===== sv/qmn_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_isqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// payload that travels alongside.
// ----------------------------------------------------------------------------
module qmn_isqrt #(
  parameter int unsigned PayloadW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [qmn_pkg::SUM_W-1:0]  radicand_i,
  input  logic [PayloadW-1:0]        payload_i,
  output logic                       valid_o,
  output logic [qmn_pkg::ROOT_W-1:0] root_o,
  output logic [PayloadW-1:0]        payload_o
);
  import qmn_pkg::*;

  localparam int unsigned Steps = ROOT_W;

  logic                valid_q [Steps];
  logic [REM_W-1:0]    rem_q   [Steps];
  logic [ROOT_W-1:0]   root_q  [Steps];
  logic [SUM_W-1:0]    rad_q   [Steps];
  logic [PayloadW-1:0] pay_q   [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                vin;
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [SUM_W-1:0]    rad_in;
    logic [PayloadW-1:0] pay_in;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic [REM_W-1:0]    rem_d;
    logic [ROOT_W-1:0]   root_d;

    if (k == 0) begin : g_first
      assign vin     = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand_i;
      assign pay_in  = payload_i;
    end else begin : g_next
      assign vin     = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign pay_in  = pay_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
      trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= {rad_in[SUM_W-3:0], 2'b00};
        pay_q[k]  <= pay_in;
      end
    end
  end

  assign valid_o   = valid_q[Steps-1];
  assign root_o    = root_q[Steps-1];
  assign payload_o = pay_q[Steps-1];

endmodule

// ===== sv/qmn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmn_div
// Four-lane pipelined restoring divider, one quotient bit per stage, all
// lanes sharing one divisor.
// ----------------------------------------------------------------------------
module qmn_div #(
  parameter int unsigned FracBits = 14
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [qmn_pkg::ROOT_W-1:0]                    den_i,
  input  logic [qmn_pkg::LANES-1:0][qmn_pkg::ROOT_W-1:0] rem_i,
  input  logic [qmn_pkg::LANES-1:0][FracBits:0]         nlo_i,
  input  qmn_pkg::div_side_t                            side_i,
  output logic                                          valid_o,
  output logic [qmn_pkg::LANES-1:0][FracBits:0]         quo_o,
  output qmn_pkg::div_side_t                            side_o
);
  import qmn_pkg::*;

  localparam int unsigned QW    = FracBits + 1;
  localparam int unsigned Steps = QW;

  logic                             valid_q [Steps];
  logic [ROOT_W-1:0]                den_q   [Steps];
  logic [LANES-1:0][ROOT_W-1:0]     rem_q   [Steps];
  logic [LANES-1:0][QW-1:0]         nlo_q   [Steps];
  logic [LANES-1:0][QW-1:0]         quo_q   [Steps];
  div_side_t                        side_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                         vin;
    logic [ROOT_W-1:0]            den_in;
    logic [LANES-1:0][ROOT_W-1:0] rem_in;
    logic [LANES-1:0][QW-1:0]     nlo_in;
    logic [LANES-1:0][QW-1:0]     quo_in;
    div_side_t                    side_in;
    logic [LANES-1:0][ROOT_W-1:0] rem_d;
    logic [LANES-1:0][QW-1:0]     quo_d;
    logic [LANES-1:0][QW-1:0]     nlo_d;

    if (k == 0) begin : g_first
      assign vin     = valid_i;
      assign den_in  = den_i;
      assign rem_in  = rem_i;
      assign nlo_in  = nlo_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[k-1];
      assign den_in  = den_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nlo_in  = nlo_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      logic [ROOT_W:0] rem_sh;
      logic [ROOT_W:0] den_x;
      den_x = {1'b0, den_in};
      for (int l = 0; l < LANES; l++) begin
        rem_sh   = {rem_in[l], nlo_in[l][QW-1]};
        nlo_d[l] = {nlo_in[l][QW-2:0], 1'b0};
        if (rem_sh >= den_x) begin
          rem_d[l] = ROOT_W'(rem_sh - den_x);
          quo_d[l] = {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_sh[ROOT_W-1:0];
          quo_d[l] = {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_in;
        rem_q[k]  <= rem_d;
        nlo_q[k]  <= nlo_d;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// ===== sv/quaternion_multiply_normalize.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the output is not stalled; the 32-stage root pipeline and the
// FRAC_BITS+1 stage divider each retire one bit per stage.
// A stall at the output freezes every stage; nothing is dropped.
// Reset clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Hamilton product of two Q1.14 quaternions, divided by its length and
// saturated; a zero-length product is flagged and returned as zero.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // p_w, p_x, p_y, p_z
  output logic [63:0]  m_axis_tdata_o,
  // zero_length
  output logic         m_axis_tuser_o
);
  import qmn_pkg::*;

  localparam int unsigned QW      = FRAC_BITS + 1;
  localparam int unsigned NW      = MAG_W + FRAC_BITS + 1;
  localparam int unsigned PayW    = LANES * MAG_W + LANES;
  localparam int unsigned PosLim  = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32767;
  localparam int unsigned NegLim  = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32768;

  logic en;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Products
  logic signed [COMP_W-1:0] a_c [LANES];
  logic signed [COMP_W-1:0] b_c [LANES];
  logic signed [PROD_W-1:0] prod_q [LANES*LANES];
  logic                     v1_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      a_c[i] = s_axis_tdata_i[COMP_W*i +: COMP_W];
      b_c[i] = s_axis_tdata_i[COMP_W*(i+LANES) +: COMP_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          prod_q[i*LANES+j] <= a_c[i] * b_c[j];
        end
      end
    end
  end

  // Hamilton sums
  logic signed [RAW_W-1:0] e [LANES*LANES];
  logic signed [RAW_W-1:0] raw_q [LANES];
  logic                    v2_q;

  always_comb begin
    for (int i = 0; i < LANES*LANES; i++) begin
      e[i] = RAW_W'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw_q[0] <= e[0] - e[5] - e[10] - e[15];
      raw_q[1] <= e[1] + e[4] + e[11] - e[14];
      raw_q[2] <= e[2] - e[7] + e[8] + e[13];
      raw_q[3] <= e[3] + e[6] - e[9] + e[12];
    end
  end

  // Magnitude and range reduction
  logic [RAW_W-1:0] mag [LANES];
  logic             big;
  mag_vec_t         m3_d, m3_q;
  logic [LANES-1:0] neg3_d, neg3_q;
  logic             v3_q;

  always_comb begin
    big = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      neg3_d[l] = raw_q[l][RAW_W-1];
      mag[l]    = raw_q[l][RAW_W-1] ? RAW_W'(-raw_q[l]) : RAW_W'(raw_q[l]);
      big       = big | (|mag[l][RAW_W-1:MAG_W]);
    end
    for (int l = 0; l < LANES; l++) begin
      m3_d[l] = big ? mag[l][MAG_W+1:2] : mag[l][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_q   <= m3_d;
      neg3_q <= neg3_d;
    end
  end

  // Squares
  logic [SQ_W-1:0]  sq_q [LANES];
  mag_vec_t         m4_q;
  logic [LANES-1:0] neg4_q;
  logic             v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        sq_q[l] <= SQ_W'(m3_q[l]) * SQ_W'(m3_q[l]);
      end
      m4_q   <= m3_q;
      neg4_q <= neg3_q;
    end
  end

  // Sum of squares
  logic [SUM_W-1:0] sum_q;
  mag_vec_t         m5_q;
  logic [LANES-1:0] neg5_q;
  logic             v5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]) + SUM_W'(sq_q[3]);
      m5_q   <= m4_q;
      neg5_q <= neg4_q;
    end
  end

  // Square root
  logic              vs_o;
  logic [ROOT_W-1:0] len;
  logic [PayW-1:0]   pay_o;
  mag_vec_t          ms;
  logic [LANES-1:0]  negs;

  qmn_isqrt #(
    .PayloadW (PayW)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v5_q),
    .radicand_i (sum_q),
    .payload_i  ({neg5_q, m5_q}),
    .valid_o    (vs_o),
    .root_o     (len),
    .payload_o  (pay_o)
  );

  assign ms   = pay_o[LANES*MAG_W-1:0];
  assign negs = pay_o[PayW-1 -: LANES];

  // Numerator setup
  logic [NW-1:0]                num [LANES];
  logic [LANES-1:0][ROOT_W-1:0] rem0_q;
  logic [LANES-1:0][QW-1:0]     nlo0_q;
  logic [ROOT_W-1:0]            den_q;
  div_side_t                    side_q;
  logic                         vp_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num[l] = NW'({ms[l], {FRAC_BITS{1'b0}}}) + NW'(len >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem0_q[l] <= ROOT_W'(num[l][NW-1:QW]);
        nlo0_q[l] <= num[l][QW-1:0];
      end
      den_q       <= len;
      side_q.neg  <= negs;
      side_q.zero <= (len == '0);
    end
  end

  // Division
  logic                     vd_o;
  logic [LANES-1:0][QW-1:0] quo;
  div_side_t                sided;

  qmn_div #(
    .FracBits (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vp_q),
    .den_i   (den_q),
    .rem_i   (rem0_q),
    .nlo_i   (nlo0_q),
    .side_i  (side_q),
    .valid_o (vd_o),
    .quo_o   (quo),
    .side_o  (sided)
  );

  // Saturate and output
  logic [63:0]  qx;
  logic [63:0]  qc;
  logic [63:0]  tdata_d, tdata_q;
  logic         tuser_q;
  logic         vo_q;

  always_comb begin
    tdata_d = '0;
    qx      = '0;
    qc      = '0;
    for (int l = 0; l < LANES; l++) begin
      qx = 64'(quo[l]);
      if (sided.neg[l]) begin
        qc = (qx > 64'(NegLim)) ? 64'(NegLim) : qx;
        tdata_d[COMP_W*l +: COMP_W] = COMP_W'(~qc[COMP_W-1:0] + 1'b1);
      end else begin
        qc = (qx > 64'(PosLim)) ? 64'(PosLim) : qx;
        tdata_d[COMP_W*l +: COMP_W] = qc[COMP_W-1:0];
      end
    end
    if (sided.zero) begin
      tdata_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
      tuser_q <= sided.zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vp_q <= vs_o;
      vo_q <= vd_o;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;

`ifndef SYNTH
  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("zero-length beat carries nonzero components");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (int'($signed(m_axis_tdata_o[15:0]))  <= int'(PosLim)) &&
      (int'($signed(m_axis_tdata_o[31:16])) <= int'(PosLim)) &&
      (int'($signed(m_axis_tdata_o[47:32])) <= int'(PosLim)) &&
      (int'($signed(m_axis_tdata_o[63:48])) <= int'(PosLim)) &&
      (int'($signed(m_axis_tdata_o[15:0]))  >= -int'(NegLim)) &&
      (int'($signed(m_axis_tdata_o[31:16])) >= -int'(NegLim)) &&
      (int'($signed(m_axis_tdata_o[47:32])) >= -int'(NegLim)) &&
      (int'($signed(m_axis_tdata_o[63:48])) >= -int'(NegLim)))
    else $error("component outside saturation range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vd_o) && $stable(vs_o))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== verif/tb_quaternion_multiply_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_multiply_normalize
// Streams quaternion pairs into the block and checks every output beat
// against a normalized Hamilton product computed in the bench. The bench
// covers directed corner pairs, then random pairs under three idling
// patterns on the input and output sides.
// ----------------------------------------------------------------------------
module tb_quaternion_multiply_normalize;
  import qmn_pkg::*;

  localparam int unsigned FRAC     = 14;
  localparam int unsigned N_ITEMS  = 1550;
  localparam int unsigned LIMIT    = 400000;
  localparam int unsigned DRAIN    = 200;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t [3:0] b;
    comp_t [3:0] a;
  } qpair_t;

  typedef struct packed {
    comp_t [3:0] p;
    logic        zero;
  } qprod_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;

  qpair_t pending_pairs[$];
  qprod_t expected_products[$];
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 85;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          in_fire = 1'b0;

  quaternion_multiply_normalize #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // p_w, p_x, p_y, p_z
    .m_axis_tuser_o  (m_tuser)    // zero_length
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic qprod_t normalized_product(qpair_t q);
    longint      aw, ax, ay, az, bw, bx, by, bz;
    longint      r[4];
    logic [63:0] m[4];
    logic [63:0] sum, len, qt, pos_lim, neg_lim;
    bit          neg[4];
    int          sh;
    qprod_t      res;
    aw = q.a[0]; ax = q.a[1]; ay = q.a[2]; az = q.a[3];
    bw = q.b[0]; bx = q.b[1]; by = q.b[2]; bz = q.b[3];
    r[0] = aw * bw - ax * bx - ay * by - az * bz;
    r[1] = aw * bx + ax * bw + ay * bz - az * by;
    r[2] = aw * by - ax * bz + ay * bw + az * bx;
    r[3] = aw * bz + ax * by - ay * bx + az * bw;
    sh = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = r[i] < 0;
      m[i] = neg[i] ? 64'(-r[i]) : 64'(r[i]);
      if (m[i] >= (64'd1 << 31)) sh = 2;
    end
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      m[i] = m[i] >> sh;
      sum = sum + m[i] * m[i];
    end
    len = root_floor(sum);
    res = '0;
    if (len == 0) begin
      res.zero = 1'b1;
      return res;
    end
    pos_lim = (64'd1 << FRAC) < 64'd32767 ? (64'd1 << FRAC) : 64'd32767;
    neg_lim = (64'd1 << FRAC) < 64'd32768 ? (64'd1 << FRAC) : 64'd32768;
    for (int i = 0; i < 4; i++) begin
      qt = ((m[i] << FRAC) + (len >> 1)) / len;
      if (neg[i]) begin
        if (qt > neg_lim) qt = neg_lim;
        res.p[i] = comp_t'(-qt);
      end else begin
        if (qt > pos_lim) qt = pos_lim;
        res.p[i] = comp_t'(qt);
      end
    end
    return res;
  endfunction

  function automatic comp_t rand_comp();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return comp_t'($urandom_range(32768) - 16384);
    if (sel < 88) return comp_t'($urandom);
    return comp_t'($urandom_range(6) - 3);
  endfunction

  function automatic qpair_t make_pair(int w0, int x0, int y0, int z0,
                                       int w1, int x1, int y1, int z1);
    qpair_t q;
    q.a[0] = comp_t'(w0); q.a[1] = comp_t'(x0); q.a[2] = comp_t'(y0); q.a[3] = comp_t'(z0);
    q.b[0] = comp_t'(w1); q.b[1] = comp_t'(x1); q.b[2] = comp_t'(y1); q.b[3] = comp_t'(z1);
    return q;
  endfunction

  // drive input beats and the output ready
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || in_fire)) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= pending_pairs.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // sample beats and check
  always @(posedge clk_i) begin
    qprod_t got, exp_p;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    in_fire = s_tvalid && s_tready;
    if (in_fire) expected_products.push_back(normalized_product(qpair_t'(s_tdata)));
    if (m_tvalid && m_tready) begin
      got.p = m_tdata;
      got.zero = m_tuser;
      if (expected_products.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: p=%h zero=%b", got.p, got.zero);
      end else begin
        exp_p = expected_products.pop_front();
        if (got != exp_p) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp p=%h zero=%b, got p=%h zero=%b",
                     exp_p.p, exp_p.zero, got.p, got.zero);
        end
      end
    end
  end

  initial begin
    qpair_t q;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0));
    pending_pairs.push_back(make_pair(-16384, 0, 0, 0, 16384, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 16384, 0, 0, 0, 16384, 0, 0));
    pending_pairs.push_back(make_pair(0, 16384, 0, 0, 0, 0, 16384, 0));
    pending_pairs.push_back(make_pair(0, 0, 16384, 0, 0, 0, 0, 16384));
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 0, 16384, 0, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 0, 1, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 0, -1, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 1, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(16384, 16384, 16384, 16384,
                                      16384, 16384, 16384, 16384));
    pending_pairs.push_back(make_pair(-16384, -16384, -16384, -16384,
                                      16384, -16384, 16384, -16384));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, 32767, -32768, 32767,
                                      32767, -32768, 32767, -32768));
    pending_pairs.push_back(make_pair(11585, 11585, 0, 0, 11585, 0, 11585, 0));
    pending_pairs.push_back(make_pair(3, 0, 0, 0, 0, 0, 0, 1));
    pending_pairs.push_back(make_pair(16384, 0, 0, 0, -16384, 0, 0, 0));
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 33 : 0;
      for (int n = 0; n < N_ITEMS / 3; n++) begin
        for (int i = 0; i < 4; i++) begin
          q.a[i] = rand_comp();
          q.b[i] = rand_comp();
        end
        pending_pairs.push_back(q);
      end
      while (pending_pairs.size() != 0 || s_tvalid || expected_products.size() != 0)
        @(posedge clk_i);
    end
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
